// ===== src/fpe_pkg.sv =====
package fpe_pkg;

	// Default widths of the coordinate and normal formats.
	localparam int COORD_BITS_DEF       = 24;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// Normalized cross product magnitudes carry this many significant bits.
	localparam int NORM_BITS = 31;
	// Sum of three squared magnitudes, and its integer square root.
	localparam int SUM_BITS  = 64;
	localparam int LEN_BITS  = 32;

	// Digit steps done in one register stage of the root and divider pipes.
	localparam int ISQ_STEPS = 2;
	localparam int DIV_STEPS = 2;

	// Vector components handled side by side.
	localparam int AXES = 3;

	// Face status codes.
	localparam int STATUS_BITS = 3;
	localparam logic [STATUS_BITS-1:0] ST_COMPUTED    = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_ZEROED      = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_FAKED       = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_DEGENERATE  = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_NOT_WRITTEN = 3'd4;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_BAD = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIX_BAD  = 1'b1;

	// Corner count class that marks a full triangle.
	localparam logic [1:0] COUNT_TRIANGLE = 2'd3;

endpackage

// ===== src/fpe_isqrt.sv =====
// Pipelined floor integer square root, a fixed number of digit steps per stage.
module fpe_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [fpe_pkg::SUM_BITS-1:0]  sum,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output logic [fpe_pkg::LEN_BITS-1:0]  root,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int SW   = fpe_pkg::SUM_BITS;
	localparam int RW   = SW + 1;
	localparam int NSTG = SW / 2 / fpe_pkg::ISQ_STEPS;

	logic [SW-1:0]     rem_w  [NSTG+1];
	logic [RW-1:0]     rt_w   [NSTG+1];
	logic              vld_w  [NSTG+1];
	logic [SIDE_W-1:0] side_w [NSTG+1];

	logic [SW-1:0]     rem_q  [NSTG];
	logic [RW-1:0]     rt_q   [NSTG];
	logic              vld_q  [NSTG];
	logic [SIDE_W-1:0] side_q [NSTG];

	assign rem_w[0]  = sum;
	assign rt_w[0]   = '0;
	assign vld_w[0]  = in_valid;
	assign side_w[0] = in_side;

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		logic [SW-1:0] rem_n;
		logic [RW-1:0] rt_n;

		// Restoring square root digits, highest pair of bits first.
		always_comb begin
			logic [RW-1:0] bitv;
			logic [RW-1:0] trial;
			rem_n = rem_w[g];
			rt_n  = rt_w[g];
			for (int t = 0; t < fpe_pkg::ISQ_STEPS; t++) begin
				bitv  = RW'(1) << (SW - 2 - 2 * (g * fpe_pkg::ISQ_STEPS + t));
				trial = rt_n + bitv;
				if ({1'b0, rem_n} >= trial) begin
					rem_n = rem_n - trial[SW-1:0];
					rt_n  = (rt_n >> 1) + bitv;
				end else begin
					rt_n = rt_n >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= vld_w[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g]  <= rem_n;
				rt_q[g]   <= rt_n;
				side_q[g] <= side_w[g];
			end
		end

		assign rem_w[g+1]  = rem_q[g];
		assign rt_w[g+1]   = rt_q[g];
		assign vld_w[g+1]  = vld_q[g];
		assign side_w[g+1] = side_q[g];
	end

	assign out_valid = vld_w[NSTG];
	assign root      = rt_w[NSTG][fpe_pkg::LEN_BITS-1:0];
	assign out_side  = side_w[NSTG];

endmodule

// ===== src/fpe_div.sv =====
// Pipelined rounded division of three magnitudes by a common length.
// Each lane gives floor((mag * 2^F + floor(len / 2)) / len).
module fpe_div #(
	parameter int NORMAL_FRAC_BITS = fpe_pkg::NORMAL_FRAC_BITS_DEF,
	parameter int SIDE_W           = 1
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           in_valid,
	input  logic [fpe_pkg::AXES*fpe_pkg::NORM_BITS-1:0]    mag,
	input  logic [fpe_pkg::LEN_BITS-1:0]                   len,
	input  logic [SIDE_W-1:0]                              in_side,
	output logic                                           out_valid,
	output logic [fpe_pkg::AXES*(NORMAL_FRAC_BITS+1)-1:0]  quo,
	output logic [SIDE_W-1:0]                              out_side
);

	localparam int NB   = fpe_pkg::NORM_BITS;
	localparam int LB   = fpe_pkg::LEN_BITS;
	localparam int NA   = fpe_pkg::AXES;
	localparam int QB   = NORMAL_FRAC_BITS + 1;
	localparam int UW   = NB + NORMAL_FRAC_BITS + 1;
	localparam int RMW  = LB + 1;
	localparam int NSTG = (QB + fpe_pkg::DIV_STEPS - 1) / fpe_pkg::DIV_STEPS;

	logic [UW-1:0]     num_w  [NSTG+1][NA];
	logic [RMW-1:0]    rem_w  [NSTG+1][NA];
	logic [QB-1:0]     quo_w  [NSTG+1][NA];
	logic [LB-1:0]     len_w  [NSTG+1];
	logic              vld_w  [NSTG+1];
	logic [SIDE_W-1:0] side_w [NSTG+1];

	logic [UW-1:0]     num_q  [NSTG][NA];
	logic [RMW-1:0]    rem_q  [NSTG][NA];
	logic [QB-1:0]     quo_q  [NSTG][NA];
	logic [LB-1:0]     len_q  [NSTG];
	logic              vld_q  [NSTG];
	logic [SIDE_W-1:0] side_q [NSTG];

	// Rounded numerator; its top bits form the starting partial remainder.
	for (genvar l = 0; l < NA; l++) begin : g_in
		assign num_w[0][l] = (UW'(mag[l*NB +: NB]) << NORMAL_FRAC_BITS) + UW'(len >> 1);
		assign rem_w[0][l] = RMW'(num_w[0][l] >> QB);
		assign quo_w[0][l] = '0;
	end
	assign len_w[0]  = len;
	assign vld_w[0]  = in_valid;
	assign side_w[0] = in_side;

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		logic [RMW-1:0] rem_n [NA];
		logic [QB-1:0]  quo_n [NA];

		// Restoring division, one quotient bit per step.
		always_comb begin
			int k;
			for (int l = 0; l < NA; l++) begin
				rem_n[l] = rem_w[g][l];
				quo_n[l] = quo_w[g][l];
				for (int t = 0; t < fpe_pkg::DIV_STEPS; t++) begin
					k = g * fpe_pkg::DIV_STEPS + t;
					if (k < QB) begin
						rem_n[l] = {rem_n[l][RMW-2:0], num_w[g][l][(k < QB) ? (QB - 1 - k) : 0]};
						if (rem_n[l] >= {1'b0, len_w[g]}) begin
							rem_n[l] = rem_n[l] - {1'b0, len_w[g]};
							quo_n[l] = {quo_n[l][QB-2:0], 1'b1};
						end else begin
							quo_n[l] = {quo_n[l][QB-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= vld_w[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[g]  <= num_w[g];
				rem_q[g]  <= rem_n;
				quo_q[g]  <= quo_n;
				len_q[g]  <= len_w[g];
				side_q[g] <= side_w[g];
			end
		end

		assign num_w[g+1]  = num_q[g];
		assign rem_w[g+1]  = rem_q[g];
		assign quo_w[g+1]  = quo_q[g];
		assign len_w[g+1]  = len_q[g];
		assign vld_w[g+1]  = vld_q[g];
		assign side_w[g+1] = side_q[g];
	end

	for (genvar l = 0; l < NA; l++) begin : g_out
		assign quo[l*QB +: QB] = quo_w[NSTG][l];
	end
	assign out_valid = vld_w[NSTG];
	assign out_side  = side_w[NSTG];

endmodule

// ===== src/face_plane_equation_top.sv =====
// Plane equation of one face per transaction. The slave side takes three
// vertices a, b, c in signed fixed point and a corner count class; the master
// side returns the unit normal of (b-a) x (b-c) in signed Q1.F, the offset
// d = -dot(n, b) and a status code. Degenerate or short faces are zeroed,
// given the normal (1,0,0) or flagged as the two mode registers select.
// The pipeline takes a new face every cycle while the output is drained.
// The pipe has eight stages of cross product and normalization,
// sixteen stages of the square root (two digits each), the divider
// (two quotient bits per stage per component), then dot product and
// output. A stall on the master side holds the whole pipe;
// configuration writes are accepted in any cycle.
module face_plane_equation_top #(
	parameter int COORD_BITS       = fpe_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = fpe_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// first_x, first_y, first_z, second_x, second_y, second_z,
	// third_x, third_y, third_z, corner_count, zero padding
	input  logic [((9*COORD_BITS+2+7)/8)*8-1:0]                       s_axis_tdata,
	input  logic                                                      s_axis_tvalid,
	output logic                                                      s_axis_tready,
	// normal_x, normal_y, normal_z, plane_offset, zero padding
	output logic [((3*(NORMAL_FRAC_BITS+2)+COORD_BITS+1+7)/8)*8-1:0]  m_axis_tdata,
	// face_status
	output logic [fpe_pkg::STATUS_BITS-1:0]                           m_axis_tuser,
	output logic                                                      m_axis_tvalid,
	input  logic                                                      m_axis_tready,
	input  logic                                                      cfg_valid,
	output logic                                                      cfg_ready,
	input  logic [fpe_pkg::CFG_INDEX_BITS-1:0]                        cfg_index,
	input  logic                                                      cfg_data
);

	localparam int CB    = COORD_BITS;
	localparam int F     = NORMAL_FRAC_BITS;
	localparam int NA    = fpe_pkg::AXES;
	localparam int DW    = CB + 1;
	localparam int PW    = 2 * DW;
	localparam int XW    = PW + 1;
	localparam int MAGW  = 2 * CB + 1;
	localparam int TW    = $clog2(MAGW + 1);
	localparam int NB    = fpe_pkg::NORM_BITS;
	localparam int SQW   = 2 * NB;
	localparam int SUMW  = fpe_pkg::SUM_BITS;
	localparam int LB    = fpe_pkg::LEN_BITS;
	localparam int QB    = F + 1;
	localparam int NW    = F + 2;
	localparam int OW    = CB + 1;
	localparam int DPW   = NW + CB;
	localparam int DSW   = DPW + 2;
	localparam int OUT_W = ((3 * NW + OW + 7) / 8) * 8;
	// Side band through the divider: degenerate, signs, b, a.x, count.
	localparam int SIDE2 = 1 + NA + NA * CB + CB + 2;
	// Side band through the root adds the three normalized magnitudes.
	localparam int SIDE1 = NA * NB + SIDE2;

	// Mode registers.
	logic zero_bad_q;
	logic fix_bad_q;

	logic adv;

	logic signed [CB-1:0] in_a [NA];
	logic signed [CB-1:0] in_b [NA];
	logic signed [CB-1:0] in_c [NA];
	logic [1:0]           in_cnt;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [DW-1:0] u_s1 [NA];
	logic signed [DW-1:0] v_s1 [NA];
	logic signed [PW-1:0] p_s2 [2*NA];
	logic signed [XW-1:0] x_s3 [NA];
	logic [MAGW-1:0]      mag_s4 [NA];
	logic [MAGW-1:0]      mag_s5 [NA];
	logic [NB-1:0]        m_s6 [NA];
	logic [NB-1:0]        m_s7 [NA];
	logic [NB-1:0]        m_s8 [NA];
	logic [SQW-1:0]       sq_s7 [NA];
	logic [SUMW-1:0]      sum_s8;
	logic [NA-1:0]        neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [TW-1:0]        top_s5;
	logic                 degen_s6, degen_s7, degen_s8;

	// Vertex b, a.x and count travel down the front pipe.
	logic [CB-1:0] b_s1 [NA], b_s2 [NA], b_s3 [NA], b_s4 [NA];
	logic [CB-1:0] b_s5 [NA], b_s6 [NA], b_s7 [NA], b_s8 [NA];
	logic [CB-1:0] ax_s1, ax_s2, ax_s3, ax_s4, ax_s5, ax_s6, ax_s7, ax_s8;
	logic [1:0]    cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6, cnt_s7, cnt_s8;

	logic [MAGW-1:0]    mor;
	logic [TW-1:0]      top_n;
	logic [SIDE1-1:0]   side1_in, side1_out;
	logic [SIDE2-1:0]   side2_out;
	logic               isq_vld;
	logic [LB-1:0]      isq_len;
	logic [NA*NB-1:0]   isq_mag;
	logic               div_vld;
	logic [NA*QB-1:0]   div_quo;

	logic                  degen_d;
	logic [NA-1:0]         neg_d;
	logic [CB-1:0]         b_d [NA];
	logic [CB-1:0]         ax_d;
	logic [1:0]            cnt_d;

	logic                  vld_s9;
	logic signed [NW-1:0]  n_s9 [NA];
	logic signed [DPW-1:0] dp_s9 [NA];
	logic                  degen_s9;
	logic [CB-1:0]         bx_s9;
	logic [CB-1:0]         ax_s9;
	logic [1:0]            cnt_s9;

	logic                  vld_s10;
	logic [NW-1:0]         nx_s10, ny_s10, nz_s10;
	logic [OW-1:0]         off_s10;
	logic [fpe_pkg::STATUS_BITS-1:0] st_s10;

	logic signed [DSW-1:0] dsum;
	logic signed [DSW-1:0] drnd;
	logic signed [DSW-1:0] dshr;
	logic [DSW-1:0]        dneg;
	logic [NW-1:0]         nx_n, ny_n, nz_n;
	logic [OW-1:0]         off_n;
	logic [fpe_pkg::STATUS_BITS-1:0] st_n;

	// The whole pipe moves when the output register is free or being taken.
	assign adv           = !vld_s10 || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_bad_q <= 1'b0;
			fix_bad_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fpe_pkg::REG_ZERO_BAD: zero_bad_q <= cfg_data;
				fpe_pkg::REG_FIX_BAD:  fix_bad_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input field unpacking.
	for (genvar i = 0; i < NA; i++) begin : g_unpack
		assign in_a[i] = s_axis_tdata[i*CB +: CB];
		assign in_b[i] = s_axis_tdata[(NA+i)*CB +: CB];
		assign in_c[i] = s_axis_tdata[(2*NA+i)*CB +: CB];
	end
	assign in_cnt = s_axis_tdata[3*NA*CB +: 2];

	// Valid bits of the front pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Leading one of the largest magnitude.
	always_comb begin
		mor   = mag_s4[0] | mag_s4[1] | mag_s4[2];
		top_n = '0;
		for (int j = 0; j < MAGW; j++) begin
			if (mor[j]) begin
				top_n = TW'(j + 1);
			end
		end
	end

	// Front pipe: edges, products, cross product, magnitude, normalization, squares.
	always_ff @(posedge clk) begin
		logic [XW-1:0]      absx;
		logic [MAGW+NB-1:0] shw;
		if (adv) begin
			for (int i = 0; i < NA; i++) begin
				u_s1[i] <= DW'(in_b[i]) - DW'(in_a[i]);
				v_s1[i] <= DW'(in_b[i]) - DW'(in_c[i]);
				b_s1[i] <= in_b[i];
			end
			p_s2[0] <= u_s1[1] * v_s1[2];
			p_s2[1] <= u_s1[2] * v_s1[1];
			p_s2[2] <= u_s1[2] * v_s1[0];
			p_s2[3] <= u_s1[0] * v_s1[2];
			p_s2[4] <= u_s1[0] * v_s1[1];
			p_s2[5] <= u_s1[1] * v_s1[0];
			for (int i = 0; i < NA; i++) begin
				x_s3[i] <= XW'(p_s2[2*i]) - XW'(p_s2[2*i+1]);
				neg_s4[i] <= x_s3[i][XW-1];
				absx = x_s3[i][XW-1] ? XW'(-x_s3[i]) : XW'(x_s3[i]);
				mag_s4[i] <= absx[MAGW-1:0];
				mag_s5[i] <= mag_s4[i];
				shw = {mag_s5[i], NB'(0)} >> top_s5;
				m_s6[i]  <= shw[NB-1:0];
				m_s7[i]  <= m_s6[i];
				sq_s7[i] <= SQW'(m_s6[i]) * SQW'(m_s6[i]);
				m_s8[i]  <= m_s7[i];
			end
			top_s5   <= top_n;
			neg_s5   <= neg_s4;
			neg_s6   <= neg_s5;
			neg_s7   <= neg_s6;
			neg_s8   <= neg_s7;
			degen_s6 <= (top_s5 == '0);
			degen_s7 <= degen_s6;
			degen_s8 <= degen_s7;
			sum_s8   <= SUMW'(sq_s7[0]) + SUMW'(sq_s7[1]) + SUMW'(sq_s7[2]);

			b_s2 <= b_s1;
			b_s3 <= b_s2;
			b_s4 <= b_s3;
			b_s5 <= b_s4;
			b_s6 <= b_s5;
			b_s7 <= b_s6;
			b_s8 <= b_s7;
			ax_s1 <= in_a[0];
			ax_s2 <= ax_s1;
			ax_s3 <= ax_s2;
			ax_s4 <= ax_s3;
			ax_s5 <= ax_s4;
			ax_s6 <= ax_s5;
			ax_s7 <= ax_s6;
			ax_s8 <= ax_s7;
			cnt_s1 <= in_cnt;
			cnt_s2 <= cnt_s1;
			cnt_s3 <= cnt_s2;
			cnt_s4 <= cnt_s3;
			cnt_s5 <= cnt_s4;
			cnt_s6 <= cnt_s5;
			cnt_s7 <= cnt_s6;
			cnt_s8 <= cnt_s7;
		end
	end

	// Side band packing for the root and divider pipes.
	assign side1_in = {cnt_s8, ax_s8, b_s8[2], b_s8[1], b_s8[0], neg_s8, degen_s8,
	                   m_s8[2], m_s8[1], m_s8[0]};

	fpe_isqrt #(
		.SIDE_W (SIDE1)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s8),
		.sum       (sum_s8),
		.in_side   (side1_in),
		.out_valid (isq_vld),
		.root      (isq_len),
		.out_side  (side1_out)
	);

	assign isq_mag = side1_out[NA*NB-1:0];

	fpe_div #(
		.NORMAL_FRAC_BITS (F),
		.SIDE_W           (SIDE2)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (isq_vld),
		.mag       (isq_mag),
		.len       (isq_len),
		.in_side   (side1_out[SIDE1-1:NA*NB]),
		.out_valid (div_vld),
		.quo       (div_quo),
		.out_side  (side2_out)
	);

	// Side band unpacking after the divider.
	assign degen_d = side2_out[0];
	assign neg_d   = side2_out[1 +: NA];
	for (genvar i = 0; i < NA; i++) begin : g_side
		assign b_d[i] = side2_out[1+NA+i*CB +: CB];
	end
	assign ax_d  = side2_out[1+NA+NA*CB +: CB];
	assign cnt_d = side2_out[1+NA+NA*CB+CB +: 2];

	// Signed normal and its products with vertex b.
	always_ff @(posedge clk) begin
		logic signed [NW-1:0] nv;
		if (adv) begin
			for (int i = 0; i < NA; i++) begin
				nv = neg_d[i] ? -NW'(div_quo[i*QB +: QB]) : NW'(div_quo[i*QB +: QB]);
				n_s9[i]  <= nv;
				dp_s9[i] <= DPW'(nv) * DPW'(signed'(b_d[i]));
			end
			degen_s9 <= degen_d;
			bx_s9    <= b_d[0];
			ax_s9    <= ax_d;
			cnt_s9   <= cnt_d;
		end
	end

	// Offset rounding and selection of the special cases.
	always_comb begin
		dsum = DSW'(dp_s9[0]) + DSW'(dp_s9[1]) + DSW'(dp_s9[2]);
		drnd = dsum + (DSW'(1) << (F - 1));
		dshr = drnd >>> F;
		dneg = DSW'(0) - dshr;
		nx_n = '0;
		ny_n = '0;
		nz_n = '0;
		off_n = '0;
		if (cnt_s9 == fpe_pkg::COUNT_TRIANGLE && !degen_s9) begin
			nx_n  = n_s9[0];
			ny_n  = n_s9[1];
			nz_n  = n_s9[2];
			off_n = dneg[OW-1:0];
			st_n  = fpe_pkg::ST_COMPUTED;
		end else if (zero_bad_q) begin
			st_n = fpe_pkg::ST_ZEROED;
		end else if (cnt_s9 == fpe_pkg::COUNT_TRIANGLE && fix_bad_q) begin
			nx_n  = NW'(1) << F;
			off_n = OW'(0) - OW'(signed'(bx_s9));
			st_n  = fpe_pkg::ST_FAKED;
		end else if (cnt_s9 == fpe_pkg::COUNT_TRIANGLE) begin
			st_n = fpe_pkg::ST_DEGENERATE;
		end else if (fix_bad_q && cnt_s9 != 2'd0) begin
			nx_n  = NW'(1) << F;
			off_n = OW'(0) - OW'(signed'(ax_s9));
			st_n  = fpe_pkg::ST_FAKED;
		end else begin
			st_n = fpe_pkg::ST_NOT_WRITTEN;
		end
	end

	// Back pipe valid bits; the last stage is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s9  <= div_vld;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s10  <= nx_n;
			ny_s10  <= ny_n;
			nz_s10  <= nz_n;
			off_s10 <= off_n;
			st_s10  <= st_n;
		end
	end

	assign m_axis_tvalid = vld_s10;
	assign m_axis_tdata  = OUT_W'({off_s10, nz_s10, ny_s10, nx_s10});
	assign m_axis_tuser  = st_s10;

endmodule

// ===== bench/tb_face_plane_equation_top.sv =====
module tb_face_plane_equation_top;

	typedef struct packed {
		logic [1:0]        count;
		logic [8:0][23:0]  coord;
	} face_t;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [24:0] offset;
		logic [2:0]  status;
	} plane_t;

	// Holds the mode registers and the planes still owed by the block.
	class plane_scoreboard;
		bit zero_mode;
		bit fix_mode;
		plane_t owed[$];
		int errors;

		function plane_t plane_of(face_t f);
			longint a[3], b[3], c[3], u[3], v[3], cr[3], ns[3], dot;
			bit [63:0] mag[3], m[3], sum, len, r, cand, n;
			bit neg[3];
			int top, sh;
			plane_t p;
			p = '0;
			for (int i = 0; i < 3; i++) begin
				a[i] = $signed(f.coord[i]);
				b[i] = $signed(f.coord[3+i]);
				c[i] = $signed(f.coord[6+i]);
				u[i] = b[i] - a[i];
				v[i] = b[i] - c[i];
			end
			if (f.count == fpe_pkg::COUNT_TRIANGLE) begin
				cr[0] = u[1]*v[2] - u[2]*v[1];
				cr[1] = u[2]*v[0] - u[0]*v[2];
				cr[2] = u[0]*v[1] - u[1]*v[0];
				top = 0;
				for (int i = 0; i < 3; i++) begin
					neg[i] = cr[i] < 0;
					mag[i] = neg[i] ? -cr[i] : cr[i];
					if ($clog2(mag[i] + 1) > top) top = $clog2(mag[i] + 1);
				end
				if (top != 0) begin
					// Scale the magnitudes so the largest has 31 significant bits.
					sh = top - fpe_pkg::NORM_BITS;
					sum = 0;
					for (int i = 0; i < 3; i++) begin
						m[i] = (sh > 0) ? (mag[i] >> sh) : (mag[i] << (-sh));
						sum += m[i] * m[i];
					end
					r = 0;
					for (int k = 31; k >= 0; k--) begin
						cand = r | (64'd1 << k);
						if (cand * cand <= sum) r = cand;
					end
					len = r;
					dot = 0;
					for (int i = 0; i < 3; i++) begin
						n = ((m[i] << 14) + (len >> 1)) / len;
						ns[i] = neg[i] ? -longint'(n) : longint'(n);
						dot += ns[i] * b[i];
					end
					dot = (dot + 8192) >>> 14;
					p.nx = ns[0][15:0];
					p.ny = ns[1][15:0];
					p.nz = ns[2][15:0];
					p.offset = 25'(-dot);
					p.status = fpe_pkg::ST_COMPUTED;
				end else if (zero_mode) begin
					p.status = fpe_pkg::ST_ZEROED;
				end else if (fix_mode) begin
					p.nx = 16'd16384;
					p.offset = 25'(-b[0]);
					p.status = fpe_pkg::ST_FAKED;
				end else begin
					p.status = fpe_pkg::ST_DEGENERATE;
				end
			end else if (zero_mode) begin
				p.status = fpe_pkg::ST_ZEROED;
			end else if (fix_mode && f.count != 0) begin
				p.nx = 16'd16384;
				p.offset = 25'(-a[0]);
				p.status = fpe_pkg::ST_FAKED;
			end else begin
				p.status = fpe_pkg::ST_NOT_WRITTEN;
			end
			return p;
		endfunction

		function void note_face(face_t f);
			owed.push_back(plane_of(f));
		endfunction

		function void check_plane(plane_t got);
			plane_t e;
			if (owed.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.nx !== e.nx) begin
				$error("normal_x expected %0d got %0d", $signed(e.nx), $signed(got.nx));
				errors++;
			end
			if (got.ny !== e.ny) begin
				$error("normal_y expected %0d got %0d", $signed(e.ny), $signed(got.ny));
				errors++;
			end
			if (got.nz !== e.nz) begin
				$error("normal_z expected %0d got %0d", $signed(e.nz), $signed(got.nz));
				errors++;
			end
			if (got.offset !== e.offset) begin
				$error("plane_offset expected %0d got %0d", $signed(e.offset),
					$signed(got.offset));
				errors++;
			end
			if (got.status !== e.status) begin
				$error("face_status expected %0d got %0d", e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic [223:0] s_axis_tdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [79:0]  m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [fpe_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic         cfg_data;

	plane_scoreboard planes = new();
	int  cycles;
	bit  no_gaps;
	int  stall_left;

	face_plane_equation_top i_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: random back-pressure, mostly short stalls.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!no_gaps && $urandom_range(0, 99) < 25)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			planes.check_plane({m_axis_tdata[15:0], m_axis_tdata[31:16],
				m_axis_tdata[47:32], m_axis_tdata[72:48], m_axis_tuser});
	end

	task automatic send_face(face_t f);
		int gap;
		@(negedge clk);
		s_axis_tdata  = {6'b0, f.count, f.coord};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		planes.note_face(f);
		gap = 0;
		if (!no_gaps && $urandom_range(0, 99) < 45)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(1, 3);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_mode(logic [fpe_pkg::CFG_INDEX_BITS-1:0] idx, bit value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == fpe_pkg::REG_ZERO_BAD) planes.zero_mode = value;
		else planes.fix_mode = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Let the pipe drain fully before touching the mode registers.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (planes.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return 24'($urandom_range(0, 32767)) - 24'd16384;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic face_t random_face();
		face_t f;
		int k;
		for (int i = 0; i < 9; i++) f.coord[i] = pick_coord();
		f.count = ($urandom_range(0, 9) < 7) ? fpe_pkg::COUNT_TRIANGLE
			: 2'($urandom_range(0, 3));
		// Some faces are made collinear or have coincident corners.
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, 3) - 1;
			for (int i = 0; i < 3; i++) begin
				f.coord[i]   = 24'($urandom_range(0, 8191)) - 24'd4096;
				f.coord[3+i] = 24'($urandom_range(0, 8191)) - 24'd4096;
				f.coord[6+i] = 24'($signed(f.coord[3+i])
					+ k * ($signed(f.coord[3+i]) - $signed(f.coord[i])));
			end
		end
		return f;
	endfunction

	task automatic directed_faces();
		face_t f;
		f = '0; f.count = fpe_pkg::COUNT_TRIANGLE;
		f.coord[3] = 24'd4096; f.coord[7] = 24'd4096;
		send_face(f);
		f = '0; f.count = fpe_pkg::COUNT_TRIANGLE;
		send_face(f);
		f.coord = {9{24'h7FFFFF}};
		send_face(f);
		f.coord = {24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
			24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000};
		send_face(f);
		f.coord = {24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
			24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000};
		send_face(f);
		// Collinear corners.
		f.coord = {24'd300, 24'd200, 24'd100, 24'd30, 24'd20, 24'd10,
			24'd3, 24'd2, 24'd1};
		send_face(f);
		for (int c = 0; c < 3; c++) begin
			f.count = 2'(c);
			f.coord[0] = 24'h800000;
			send_face(f);
			f.coord[0] = 24'h7FFFFF;
			send_face(f);
		end
		f = random_face(); f.count = fpe_pkg::COUNT_TRIANGLE;
		send_face(f);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = fpe_pkg::REG_ZERO_BAD;
		cfg_data      = 1'b0;
		cycles        = 0;
		stall_left    = 0;
		no_gaps       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk through every mode setting, ending with both modes set.
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				drain();
				write_mode(fpe_pkg::REG_ZERO_BAD, phase == 2 || phase == 4 ? 1'b1 : 1'b0);
				write_mode(fpe_pkg::REG_FIX_BAD, phase == 3 || phase == 4 ? 1'b1 : 1'b0);
			end
			directed_faces();
			for (int n = 0; n < 350; n++) begin
				if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
				send_face(random_face());
			end
			no_gaps = 1'b0;
		end
		drain();

		if (planes.errors == 0 && planes.owed.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== sim.f =====
src/fpe_pkg.sv
src/fpe_isqrt.sv
src/fpe_div.sv
src/face_plane_equation_top.sv
bench/tb_face_plane_equation_top.sv
